// ===== rtl/lfoa_pkg.sv =====
// ----------------------------------------------------------------------------
// lfoa_pkg
// shared widths and register indexes for the leapfrog oscillator adjoint unit
// ----------------------------------------------------------------------------
package lfoa_pkg;

  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = DATA_W + 2;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_TIME_STEP = 1'd0;
  localparam cfg_idx_t CFG_STIFFNESS = 1'd1;

  // reset values, 1.0 in Q16.16
  localparam logic [STEP_W-1:0] STEP_RESET  = 31'd65536;
  localparam word_t             STIFF_RESET = 32'sd65536;

endpackage

// ===== rtl/lfoa_in_if.sv =====
// ----------------------------------------------------------------------------
// lfoa_in_if
// trajectory sample channel: valid/ready plus one sample
// ----------------------------------------------------------------------------
interface lfoa_in_if
  import lfoa_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t position;
  word_t pos_grad;
  word_t vel_grad;
  word_t acc_grad;
  logic  first;
  logic  last;

  modport source (
    output valid, position, pos_grad, vel_grad, acc_grad, first, last,
    input  ready
  );

  modport sink (
    input  valid, position, pos_grad, vel_grad, acc_grad, first, last,
    output ready
  );
endinterface

// ===== rtl/lfoa_out_if.sv =====
// ----------------------------------------------------------------------------
// lfoa_out_if
// result channel: valid/ready plus the initial-state and stiffness adjoints
// ----------------------------------------------------------------------------
interface lfoa_out_if
  import lfoa_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t init_pos_grad;
  word_t init_vel_grad;
  word_t stiffness_grad;

  modport source (
    output valid, init_pos_grad, init_vel_grad, stiffness_grad,
    input  ready
  );

  modport sink (
    input  valid, init_pos_grad, init_vel_grad, stiffness_grad,
    output ready
  );
endinterface

// ===== rtl/leapfrog_oscillator_adjoint_unit.sv =====
// ----------------------------------------------------------------------------
// leapfrog_oscillator_adjoint_unit
// reverse-mode adjoint of a leapfrog oscillator trajectory, one shared multiplier
// result: a last request's result is loaded into the output register from S_EMIT,
//   which waits while the output register still holds an unaccepted result
// requests: a new one is accepted only in S_IDLE, once the previous one is done;
//   up to five products per request share one 32x32 multiplier
// reset: synchronous active-low rst_n clears the adjoint state to zero, sets the
//   time step and stiffness to 1.0 and empties the output register
// ----------------------------------------------------------------------------
module leapfrog_oscillator_adjoint_unit
  import lfoa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_idx,
  input  logic [DATA_W-1:0] cfg_data,
  lfoa_in_if.sink       in_req,
  lfoa_out_if.source    out_res
);

  // sequencer codes: Mn issues product n, An scales and accumulates it
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;  // h*half into acc
  localparam logic [3:0] S_A1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;  // h*vel into acc
  localparam logic [3:0] S_A2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;  // x*acc out of stiff
  localparam logic [3:0] S_A3   = 4'd6;
  localparam logic [3:0] S_M4   = 4'd7;  // k*acc out of pos
  localparam logic [3:0] S_A4   = 4'd8;
  localparam logic [3:0] S_M5   = 4'd9;  // pos*h onto vel, gives half
  localparam logic [3:0] S_A5   = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  // 32-bit signed limits, sign-extended to the wider paths
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic signed [PROD_W-1:0] WMAX = PROD_W'(WORD_MAX);
  localparam logic signed [PROD_W-1:0] WMIN = PROD_W'(WORD_MIN);
  localparam logic signed [SUM_W-1:0]  SMAX = SUM_W'(WORD_MAX);
  localparam logic signed [SUM_W-1:0]  SMIN = SUM_W'(WORD_MIN);

  function automatic word_t sat_prod(input logic signed [PROD_W-1:0] v);
    if (v > WMAX) return WMAX[DATA_W-1:0];
    if (v < WMIN) return WMIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  function automatic word_t sat_sum(input logic signed [SUM_W-1:0] v);
    if (v > SMAX) return SMAX[DATA_W-1:0];
    if (v < SMIN) return SMIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  // configuration
  logic [STEP_W-1:0] step_r;
  word_t             k_r;

  // adjoint state
  word_t pos_r, vel_r, acc_r, half_r, stiff_r;
  word_t pos_nxt, vel_nxt, acc_nxt, half_nxt, stiff_nxt;

  // latched request
  word_t x_r;
  logic  last_r;

  // sequencer and shared multiplier
  logic [3:0]               state_r, state_nxt;
  logic signed [PROD_W-1:0] prod_r;
  word_t                    mul_a, mul_b;
  logic                     mul_en;

  // output register
  logic  out_valid_r, out_valid_nxt;
  word_t out_pos_r, out_vel_r, out_stiff_r;
  logic  out_load;

  // scale and accumulate path
  logic                     half_scale, negate;
  logic signed [PROD_W-1:0] shifted;
  word_t                    term, target, acc_res;
  logic signed [SUM_W-1:0]  term_ext, sum;
  logic                     in_take;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_take      = in_req.valid & in_req.ready;

  assign out_res.valid          = out_valid_r;
  assign out_res.init_pos_grad  = out_pos_r;
  assign out_res.init_vel_grad  = out_vel_r;
  assign out_res.stiffness_grad = out_stiff_r;

  // operand select for the multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_M1: begin
        mul_a = word_t'({1'b0, step_r});
        mul_b = half_r;
      end
      S_M2: begin
        mul_a = word_t'({1'b0, step_r});
        mul_b = vel_r;
      end
      S_M3: begin
        mul_a = x_r;
        mul_b = acc_r;
      end
      S_M4: begin
        mul_a = k_r;
        mul_b = acc_r;
      end
      S_M5: begin
        mul_a = pos_r;
        mul_b = word_t'({1'b0, step_r});
      end
      default: mul_en = 1'b0;
    endcase
  end

  // floor shift, saturate, optional negate, then saturating add to the target
  always_comb begin
    half_scale = (state_r == S_A1) || (state_r == S_A2);
    negate     = (state_r == S_A3) || (state_r == S_A4);
    shifted    = half_scale ? (prod_r >>> (FRAC_BITS + 1)) : (prod_r >>> FRAC_BITS);
    term       = sat_prod(shifted);
    term_ext   = negate ? -SUM_W'(term) : SUM_W'(term);
    case (state_r)
      S_A3:    target = stiff_r;
      S_A4:    target = pos_r;
      S_A5:    target = vel_r;
      default: target = acc_r;
    endcase
    sum     = SUM_W'(target) + term_ext;
    acc_res = sat_sum(sum);
  end

  // sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    acc_nxt       = acc_r;
    half_nxt      = half_r;
    stiff_nxt     = stiff_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_res.ready;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          acc_nxt = in_req.acc_grad;
          if (in_req.first) begin
            // new trajectory: load the adjoints, no half-step term
            pos_nxt   = in_req.pos_grad;
            vel_nxt   = in_req.vel_grad;
            stiff_nxt = '0;
            state_nxt = in_req.last ? S_M3 : S_M2;
          end else begin
            pos_nxt   = sat_sum(SUM_W'(pos_r) + SUM_W'(in_req.pos_grad));
            vel_nxt   = sat_sum(SUM_W'(in_req.vel_grad) + SUM_W'(half_r));
            state_nxt = S_M1;
          end
        end
      end
      S_M1: state_nxt = S_A1;
      S_A1: begin
        acc_nxt   = acc_res;
        state_nxt = last_r ? S_M3 : S_M2;
      end
      S_M2: state_nxt = S_A2;
      S_A2: begin
        acc_nxt   = acc_res;
        state_nxt = S_M3;
      end
      S_M3: state_nxt = S_A3;
      S_A3: begin
        stiff_nxt = acc_res;
        state_nxt = S_M4;
      end
      S_M4: state_nxt = S_A4;
      S_A4: begin
        pos_nxt   = acc_res;
        state_nxt = last_r ? S_EMIT : S_M5;
      end
      S_M5: state_nxt = S_A5;
      S_A5: begin
        // half-step velocity adjoint starts from the new velocity adjoint
        half_nxt  = acc_res;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_res.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
      k_r         <= STIFF_RESET;
      pos_r       <= '0;
      vel_r       <= '0;
      acc_r       <= '0;
      half_r      <= '0;
      stiff_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      acc_r       <= acc_nxt;
      half_r      <= half_nxt;
      stiff_r     <= stiff_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TIME_STEP: step_r <= cfg_data[STEP_W-1:0];
          CFG_STIFFNESS: k_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r     <= in_req.position;
      last_r  <= in_req.last;
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (out_load) begin
      out_pos_r   <= pos_r;
      out_vel_r   <= vel_r;
      out_stiff_r <= stiff_r;
    end
  end

endmodule
